### rtl/cvg_pkg.sv
// Package for the character video generator: request and port codes,
// window addresses, frame geometry and the sequencer state and operation types.
// No dependencies.
package cvg_pkg;

    localparam int PAGE_DEPTH_DEFAULT = 1024;
    localparam int FONT_DEPTH = 2048;
    localparam int FONT_LINES = 16;
    localparam int FONT_AW = $clog2(FONT_DEPTH);
    localparam int LINE_W = $clog2(FONT_LINES);

    localparam logic [1:0] REQ_REG_WRITE = 2'd0;
    localparam logic [1:0] REQ_MEM_WRITE = 2'd1;
    localparam logic [1:0] REQ_MEM_READ = 2'd2;
    localparam logic [1:0] REQ_PIXEL = 2'd3;

    localparam logic [2:0] PORT_CONTROL = 3'd3;
    localparam logic [2:0] PORT_MODE = 3'd5;
    localparam logic [2:0] PORT_POINTER = 3'd6;
    localparam logic [2:0] PORT_START = 3'd7;

    localparam logic [15:0] PAGE_WINDOW_BASE = 16'hF800;
    localparam logic [15:0] FONT_WINDOW_BASE = 16'hF400;

    localparam logic [7:0] CONTROL_RESET = 8'h10;
    localparam logic [10:0] MASK_DOUBLE = 11'h7ff;
    localparam logic [10:0] MASK_SINGLE = 11'h3ff;
    localparam logic [10:0] START_ALIGN = 11'h7fc;

    localparam logic [7:0] FRAME_WIDTH = 8'd240;
    localparam logic [8:0] FRAME_HEIGHT_16 = 9'd384;
    localparam logic [8:0] FRAME_HEIGHT_8 = 9'd192;
    localparam logic [8:0] FRAME_HEIGHT_9 = 9'd216;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_CALC  = 6'b000100,
        ST_INDEX = 6'b001000,
        ST_PAGE  = 6'b010000,
        ST_FONT  = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        OP_PAGE_READ  = 2'd0,
        OP_FONT_WRITE = 2'd1,
        OP_FONT_READ  = 2'd2,
        OP_PIXEL      = 2'd3
    } op_t;

endpackage

### rtl/character_video_generator.sv
// Character video generator top level: register file, page and font memories
// and the sequencer that serves bus accesses and pixel queries.
// Depends on cvg_pkg.
//
//  Channel  Handshake              Payload
//  input    in_valid / in_ready    req_type, port_number, bus_address, write_data,
//                                  pixel_x, pixel_y
//  output   out_valid / out_ready  read_data, address_hit, pixel_colour, in_frame
//
// One transaction is processed at a time. Register writes, page writes, blank or
// off-frame pixel queries end in ST_IDLE; page reads and font writes pass ST_PAGE;
// font reads ST_PAGE and ST_FONT; drawn pixel queries ST_CALC, ST_INDEX, ST_PAGE and
// ST_FONT. After reset both memories are cleared one entry per cycle over FONT_DEPTH
// (2048) entries, during which in_ready stays low. A result waits in the output
// register; a new transaction is accepted in the cycle the waiting result is taken.
module character_video_generator
#(
    parameter int PAGE_DEPTH = cvg_pkg::PAGE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [2:0]  port_number,
    input  logic [15:0] bus_address,
    input  logic [7:0]  write_data,
    input  logic [7:0]  pixel_x,
    input  logic [8:0]  pixel_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic        address_hit,
    output logic [2:0]  pixel_colour,
    output logic        in_frame
);
    import cvg_pkg::*;

    localparam int PAW = $clog2(PAGE_DEPTH);

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    logic [7:0]  control_reg, control_next;
    logic [7:0]  mode_reg, mode_next;
    logic [9:0]  char_pointer_reg, char_pointer_next;
    logic [10:0] page_start_reg, page_start_next;
    logic [FONT_AW-1:0] clr_cnt_reg, clr_cnt_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  read_data_reg, read_data_next;
    logic        address_hit_reg, address_hit_next;
    logic [2:0]  pixel_colour_reg, pixel_colour_next;
    logic        in_frame_reg, in_frame_next;

    logic [15:0] addr_reg, addr_next;
    logic [7:0]  data_reg, data_next;
    logic [7:0]  col_reg, col_next;
    logic [8:0]  row_reg, row_next;
    logic [5:0]  cx_reg, cx_next;
    logic [2:0]  bit_reg, bit_next;
    logic [4:0]  cy_reg, cy_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic        pcb_reg, pcb_next;

    logic [7:0]  page_mem [PAGE_DEPTH];
    logic [7:0]  font_mem [FONT_DEPTH];
    logic           page_we, page_re;
    logic [PAW-1:0] page_wa, page_ra;
    logic [7:0]     page_wd, page_rd_reg;
    logic               font_we, font_re;
    logic [FONT_AW-1:0] font_wa, font_ra;
    logic [7:0]         font_wd, font_rd_reg;

    logic        accept;
    logic        hit_page, hit_font;
    logic [10:0] page_mask;
    logic [8:0]  frame_height;
    logic [15:0] cx_prod;
    logic [7:0]  cx_six;
    logic [7:0]  col_mod;
    logic [14:0] cy9_prod;
    logic [5:0]  cy_full;
    logic [8:0]  cy_lines;
    logic [8:0]  line_full;
    logic [9:0]  cy_cols;
    logic [11:0] idx_sum;
    logic [10:0] idx;
    logic [9:0]  font_page_addr;
    logic [2:0]  fg_colour;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign address_hit = address_hit_reg;
    assign pixel_colour = pixel_colour_reg;
    assign in_frame = in_frame_reg;

    assign hit_page = bus_address >= PAGE_WINDOW_BASE;
    assign hit_font = !hit_page && (bus_address >= FONT_WINDOW_BASE);
    assign page_mask = mode_reg[6] ? MASK_DOUBLE : MASK_SINGLE;
    assign frame_height = mode_reg[5] ? FRAME_HEIGHT_16 :
                          (mode_reg[3] ? FRAME_HEIGHT_8 : FRAME_HEIGHT_9);
    assign font_page_addr = (req_type == REQ_MEM_WRITE && mode_reg[0]) ?
                            char_pointer_reg : bus_address[9:0];

    assign cx_prod = col_reg * 8'd171;
    assign cx_six = {1'b0, cx_prod[15:10], 1'b0} + {2'b00, cx_prod[15:10]} +
                    {2'b00, cx_prod[15:10]} + {2'b00, cx_prod[15:10]} +
                    {2'b00, cx_prod[15:10]};
    assign col_mod = col_reg - cx_six;
    assign cy9_prod = row_reg * 6'd57;
    assign cy_full = mode_reg[5] ? {2'b00, row_reg[8:5]} + {5'b0, 1'b0} + 6'(row_reg[8:4]) -
                     {2'b00, row_reg[8:5]} :
                     (mode_reg[3] ? row_reg[8:3] : cy9_prod[14:9]);
    assign cy_lines = mode_reg[5] ? {cy_full[4:0], 4'b0000} :
                      (mode_reg[3] ? {1'b0, cy_full[4:0], 3'b000} :
                       {1'b0, cy_full[4:0], 3'b000} + {4'b0000, cy_full[4:0]});
    assign line_full = row_reg - cy_lines;

    assign cy_cols = control_reg[7] ? 10'(cy_reg) * 10'd40 : 10'(cy_reg) * 10'd20;
    assign idx_sum = 12'(page_start_reg & page_mask) + 12'(cy_cols) + 12'(cx_reg);
    assign idx = idx_sum[10:0] & page_mask;

    always_comb
    begin
        unique case (control_reg[6:5])
            2'b00:   fg_colour = {font_rd_reg[6], font_rd_reg[7], pcb_reg};
            2'b01:   fg_colour = {font_rd_reg[6], pcb_reg, font_rd_reg[7]};
            default: fg_colour = {pcb_reg, font_rd_reg[6], font_rd_reg[7]};
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        control_next = control_reg;
        mode_next = mode_reg;
        char_pointer_next = char_pointer_reg;
        page_start_next = page_start_reg;
        clr_cnt_next = clr_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        read_data_next = read_data_reg;
        address_hit_next = address_hit_reg;
        pixel_colour_next = pixel_colour_reg;
        in_frame_next = in_frame_reg;
        addr_next = addr_reg;
        data_next = data_reg;
        col_next = col_reg;
        row_next = row_reg;
        cx_next = cx_reg;
        bit_next = bit_reg;
        cy_next = cy_reg;
        line_next = line_reg;
        pcb_next = pcb_reg;
        page_we = 1'b0;
        page_wa = bus_address[PAW-1:0];
        page_wd = write_data;
        page_re = 1'b0;
        page_ra = bus_address[PAW-1:0];
        font_we = 1'b0;
        font_wa = {page_rd_reg[6:0], addr_reg[3:0]};
        font_wd = data_reg;
        font_re = 1'b0;
        font_ra = {page_rd_reg[6:0], addr_reg[3:0]};

        unique case (state_reg)
            ST_CLEAR:
            begin
                page_we = 1'b1;
                page_wa = PAW'(clr_cnt_reg);
                page_wd = 8'h00;
                font_we = 1'b1;
                font_wa = clr_cnt_reg;
                font_wd = 8'h00;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next = bus_address;
                    data_next = write_data;
                    read_data_next = 8'h00;
                    address_hit_next = 1'b0;
                    pixel_colour_next = 3'd0;
                    in_frame_next = 1'b0;
                    unique case (req_type)
                        REQ_REG_WRITE:
                        begin
                            out_valid_next = 1'b1;
                            unique case (port_number)
                                PORT_CONTROL: control_next = write_data;
                                PORT_MODE:
                                begin
                                    mode_next = bus_address[7:0];
                                    if (bus_address[0])
                                    begin
                                        char_pointer_next = bus_address[9:0];
                                    end
                                end
                                PORT_POINTER: char_pointer_next = bus_address[9:0];
                                PORT_START:
                                    page_start_next = bus_address[10:0] & page_mask &
                                                      START_ALIGN;
                                default: ;
                            endcase
                        end
                        REQ_MEM_WRITE, REQ_MEM_READ:
                        begin
                            if (hit_page)
                            begin
                                address_hit_next = 1'b1;
                                if (req_type == REQ_MEM_WRITE)
                                begin
                                    page_we = 1'b1;
                                    out_valid_next = 1'b1;
                                end
                                else
                                begin
                                    page_re = 1'b1;
                                    op_next = OP_PAGE_READ;
                                    state_next = ST_PAGE;
                                end
                            end
                            else if (hit_font)
                            begin
                                page_re = 1'b1;
                                page_ra = PAW'(font_page_addr);
                                op_next = (req_type == REQ_MEM_WRITE) ? OP_FONT_WRITE
                                                                       : OP_FONT_READ;
                                state_next = ST_PAGE;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                            end
                        end
                        REQ_PIXEL:
                        begin
                            pixel_colour_next = control_reg[2:0];
                            if (pixel_x >= FRAME_WIDTH || pixel_y >= frame_height)
                            begin
                                out_valid_next = 1'b1;
                            end
                            else if (control_reg[4])
                            begin
                                in_frame_next = 1'b1;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                col_next = control_reg[7] ? pixel_x : {1'b0, pixel_x[7:1]};
                                row_next = mode_reg[7] ? pixel_y : {1'b0, pixel_y[8:1]};
                                op_next = OP_PIXEL;
                                state_next = ST_CALC;
                            end
                        end
                    endcase
                end
            end
            ST_CALC:
            begin
                cx_next = cx_prod[15:10];
                bit_next = 3'd5 - col_mod[2:0];
                cy_next = cy_full[4:0];
                line_next = line_full[LINE_W-1:0];
                state_next = ST_INDEX;
            end
            ST_INDEX:
            begin
                page_re = 1'b1;
                page_ra = PAW'(idx);
                state_next = ST_PAGE;
            end
            ST_PAGE:
            begin
                pcb_next = page_rd_reg[7];
                unique case (op_reg)
                    OP_PAGE_READ:
                    begin
                        read_data_next = page_rd_reg;
                        out_valid_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                    OP_FONT_WRITE:
                    begin
                        font_we = 1'b1;
                        address_hit_next = 1'b1;
                        out_valid_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                    OP_FONT_READ:
                    begin
                        font_re = 1'b1;
                        state_next = ST_FONT;
                    end
                    OP_PIXEL:
                    begin
                        font_re = 1'b1;
                        font_ra = {page_rd_reg[6:0], line_reg};
                        state_next = ST_FONT;
                    end
                endcase
            end
            ST_FONT:
            begin
                out_valid_next = 1'b1;
                state_next = ST_IDLE;
                if (op_reg == OP_PIXEL)
                begin
                    in_frame_next = 1'b1;
                    pixel_colour_next = font_rd_reg[bit_reg] ? fg_colour : control_reg[2:0];
                end
                else
                begin
                    address_hit_next = 1'b1;
                    read_data_next = font_rd_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            op_reg <= OP_PAGE_READ;
            control_reg <= CONTROL_RESET;
            mode_reg <= 8'h00;
            char_pointer_reg <= 10'd0;
            page_start_reg <= 11'd0;
            clr_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            control_reg <= control_next;
            mode_reg <= mode_next;
            char_pointer_reg <= char_pointer_next;
            page_start_reg <= page_start_next;
            clr_cnt_reg <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_data_reg <= read_data_next;
        address_hit_reg <= address_hit_next;
        pixel_colour_reg <= pixel_colour_next;
        in_frame_reg <= in_frame_next;
        addr_reg <= addr_next;
        data_reg <= data_next;
        col_reg <= col_next;
        row_reg <= row_next;
        cx_reg <= cx_next;
        bit_reg <= bit_next;
        cy_reg <= cy_next;
        line_reg <= line_next;
        pcb_reg <= pcb_next;
    end

    always_ff @(posedge clk)
    begin
        if (page_we)
        begin
            page_mem[page_wa] <= page_wd;
        end
        if (page_re)
        begin
            page_rd_reg <= page_mem[page_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (font_we)
        begin
            font_mem[font_wa] <= font_wd;
        end
        if (font_re)
        begin
            font_rd_reg <= font_mem[font_ra];
        end
    end

    a_font_stage_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FONT |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("Font stage did not deliver a result.");

    a_no_accept_over_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !(out_valid_reg && !out_ready))
        else $error("Transaction accepted while a result was still held.");

    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !out_valid_reg && !in_ready)
        else $error("Activity during the memory clearing pass.");

    a_result_kinds_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(address_hit_reg && in_frame_reg) &&
                          (read_data_reg == 8'h00 || address_hit_reg))
        else $error("Result mixes bus and pixel fields.");

endmodule
